@@ design/gicrfe_pkg.sv @@
// shared constants, register map and types of the gic register front end
`default_nettype none

package gicrfe_pkg;

    // field widths
    localparam int ADDR_W     = 48;
    localparam int ABS_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int RD_W       = 64;
    localparam int SIZE_W     = 4;
    localparam int WIDX_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAME_LSB  = 17;
    localparam int FRAME_W    = ADDR_W - FRAME_LSB;

    // stream packing
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 104;

    localparam int ENABLE_WORDS_DEFAULT = 32;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REDIST_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REDIST_SIZE = 3'd4;

    // configuration reset values
    localparam logic [ADDR_W-1:0] DIST_BASE_RESET   = 48'h0000_0800_0000;
    localparam logic [ADDR_W-1:0] DIST_SIZE_RESET   = 48'h0000_0001_0000;
    localparam logic [ADDR_W-1:0] REDIST_BASE_RESET = 48'h0000_080A_0000;
    localparam logic [ADDR_W-1:0] REDIST_SIZE_RESET = 48'h0000_0002_0000;
    localparam logic [ABS_W-1:0]  DIST_LIMIT_RESET  =
        {1'b0, DIST_BASE_RESET} + {1'b0, DIST_SIZE_RESET};
    localparam logic [ABS_W-1:0]  REDIST_LIMIT_RESET =
        {1'b0, REDIST_BASE_RESET} + {1'b0, REDIST_SIZE_RESET};

    // distributor map
    localparam logic [ADDR_W-1:0] DIST_CTLR_OFF  = 48'h0000;
    localparam logic [ADDR_W-1:0] DIST_TYPER_OFF = 48'h0004;
    localparam logic [ADDR_W-1:0] DIST_IIDR_OFF  = 48'h0008;
    localparam logic [ADDR_W-1:0] DIST_PIDR2_OFF = 48'hFFE8;

    // redistributor map, within one frame
    localparam logic [FRAME_LSB-1:0] RDIST_IIDR_OFF     = 17'h00004;
    localparam logic [FRAME_LSB-1:0] RDIST_TYPER_LO_OFF = 17'h00008;
    localparam logic [FRAME_LSB-1:0] RDIST_TYPER_HI_OFF = 17'h0000C;
    localparam logic [FRAME_LSB-1:0] RDIST_WAKER_OFF    = 17'h00014;
    localparam logic [FRAME_LSB-1:0] RDIST_PIDR2_OFF    = 17'h0FFE8;

    // identification values
    localparam logic [DATA_W-1:0] IIDR_VALUE       = 32'h0000_043B;
    localparam logic [DATA_W-1:0] PIDR2_VALUE      = 32'h0000_0030;
    localparam logic [DATA_W-1:0] DIST_TYPER_VALUE = 32'h0048_001F;
    localparam logic [7:0]        RDIST_TYPER_LOW  = 8'h10;
    localparam logic [SIZE_W-1:0] ACCESS_WORD      = 4'd4;

    // enable bank request and response
    typedef struct packed {
        logic              valid;
        logic              set;
        logic [WIDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } enable_req_t;

    typedef struct packed {
        logic              hit;
        logic              changed;
        logic [WIDX_W-1:0] idx;
        logic [DATA_W-1:0] word;
    } enable_rsp_t;

endpackage

`default_nettype wire

@@ design/gicrfe_enable_bank.sv @@
// interrupt enable bitmap with set and clear word updates
`default_nettype none

module gicrfe_enable_bank #(
    parameter int ENABLE_WORDS = gicrfe_pkg::ENABLE_WORDS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire gicrfe_pkg::enable_req_t  req,
    output gicrfe_pkg::enable_rsp_t       rsp
);
    import gicrfe_pkg::*;

    localparam int IW = (ENABLE_WORDS > 1) ? $clog2(ENABLE_WORDS) : 1;
    localparam logic [WIDX_W:0] WORDS_LIMIT = (WIDX_W + 1)'(ENABLE_WORDS);

    logic [DATA_W-1:0] bitmap_reg [ENABLE_WORDS];
    logic [DATA_W-1:0] old_word;
    logic [DATA_W-1:0] word_next;
    logic [IW-1:0]     word_sel;
    logic              in_range;

    assign in_range = ({1'b0, req.idx} < WORDS_LIMIT);
    assign word_sel = req.idx[IW-1:0];

    always_comb begin
        old_word  = in_range ? bitmap_reg[word_sel] : '0;
        word_next = req.set ? (old_word | req.data) : (old_word & ~req.data);
        rsp.hit     = req.valid && in_range;
        rsp.changed = rsp.hit && (word_next != old_word);
        rsp.idx     = rsp.hit ? req.idx : '0;
        rsp.word    = rsp.hit ? word_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENABLE_WORDS; i++) begin
                bitmap_reg[i] <= '0;
            end
        end else if (rsp.hit) begin
            bitmap_reg[word_sel] <= word_next;
        end
    end

endmodule

`default_nettype wire

@@ design/gicv3_register_front_end.sv @@
// gic distributor and redistributor register front end, top level
// path: a request accepted from s_tdata is registered in the input stage; its result is
// then registered in the result stage and driven on m_tdata
// throughput: one request per cycle, paused by cfg_valid; the input register absorbs one
// request while a result waits on m_tready, so back-to-back traffic does not bubble
// reset: synchronous active-low aresetn empties both stages, clears ctlr,
// waker and the whole enable bitmap, and loads the default window map
`default_nettype none

module gicv3_register_front_end #(
    parameter int ENABLE_WORDS = gicrfe_pkg::ENABLE_WORDS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // offset[47:0], write_data[79:48], access_size[83:80], zero pad
    input  wire logic [gicrfe_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]: 0 read, 1 write
    input  wire logic                             s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_data[63:0], enable_changed[64], enable_word_index[69:65],
    // enable_word[101:70], zero pad
    output logic [gicrfe_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gicrfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gicrfe_pkg::ADDR_W-1:0]    cfg_data
);
    import gicrfe_pkg::*;

    // configuration registers and precomputed window limits
    logic [ADDR_W-1:0] device_base_reg;
    logic [ADDR_W-1:0] dist_base_reg;
    logic [ADDR_W-1:0] dist_size_reg;
    logic [ADDR_W-1:0] redist_base_reg;
    logic [ADDR_W-1:0] redist_size_reg;
    logic [ABS_W-1:0]  dist_limit_reg;
    logic [ABS_W-1:0]  redist_limit_reg;

    // input stage
    logic              a_valid_reg, a_valid_next;
    logic              a_op_reg;
    logic [ABS_W-1:0]  a_addr_reg;
    logic [DATA_W-1:0] a_data_reg;
    logic [SIZE_W-1:0] a_size_reg;

    // result stage
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // architectural registers
    logic [DATA_W-1:0] ctlr_reg;
    logic [DATA_W-1:0] waker_reg;

    logic s_fire;
    logic out_can;
    logic a_fire;

    // configuration is always taken; a request waits behind it while cfg_valid is high
    assign cfg_ready = 1'b1;
    assign out_can   = !m_valid_reg || m_tready;
    assign a_fire    = a_valid_reg && out_can;
    assign s_tready  = (!a_valid_reg || out_can) && !cfg_valid;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_base_reg <= '0;
            dist_base_reg   <= DIST_BASE_RESET;
            dist_size_reg   <= DIST_SIZE_RESET;
            redist_base_reg <= REDIST_BASE_RESET;
            redist_size_reg <= REDIST_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEVICE_BASE: device_base_reg <= cfg_data;
                CFG_DIST_BASE:   dist_base_reg   <= cfg_data;
                CFG_DIST_SIZE:   dist_size_reg   <= cfg_data;
                CFG_REDIST_BASE: redist_base_reg <= cfg_data;
                CFG_REDIST_SIZE: redist_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window end addresses, one past the last byte, in 49 bits so they never wrap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_limit_reg   <= DIST_LIMIT_RESET;
            redist_limit_reg <= REDIST_LIMIT_RESET;
        end else begin
            dist_limit_reg   <= {1'b0, dist_base_reg} + {1'b0, dist_size_reg};
            redist_limit_reg <= {1'b0, redist_base_reg} + {1'b0, redist_size_reg};
        end
    end

    // input stage: absolute address is formed on the way in
    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_op_reg   <= s_tuser;
            a_addr_reg <= {1'b0, device_base_reg} + {1'b0, s_tdata[ADDR_W-1:0]};
            a_data_reg <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
            a_size_reg <= s_tdata[ADDR_W+DATA_W+SIZE_W-1:ADDR_W+DATA_W];
        end
    end

    // window decode; the distributor wins on overlap
    logic                 dist_hit;
    logic                 redist_hit;
    logic                 is_write;
    logic [ADDR_W-1:0]    dist_off;
    logic [ADDR_W-1:0]    redist_off;
    logic [FRAME_W-1:0]   frame;
    logic [FRAME_LSB-1:0] frame_off;
    logic [RD_W-1:0]      typer;
    logic [DATA_W-1:0]    waker_view;
    logic [RD_W-1:0]      dist_rd;
    logic [RD_W-1:0]      redist_rd;
    logic [RD_W-1:0]      read_data;
    logic                 en_range;
    enable_req_t          en_req;
    enable_rsp_t          en_rsp;

    assign is_write   = (a_op_reg == OP_WRITE);
    assign dist_hit   = (a_addr_reg >= {1'b0, dist_base_reg}) &&
                        (a_addr_reg < dist_limit_reg);
    assign redist_hit = !dist_hit && (a_addr_reg >= {1'b0, redist_base_reg}) &&
                        (a_addr_reg < redist_limit_reg);
    assign dist_off   = ADDR_W'(a_addr_reg - {1'b0, dist_base_reg});
    assign redist_off = ADDR_W'(a_addr_reg - {1'b0, redist_base_reg});

    // frame number and offset inside the 128 KiB frame
    assign frame      = redist_off[ADDR_W-1:FRAME_LSB];
    assign frame_off  = redist_off[FRAME_LSB-1:0];
    assign typer      = {1'b0, frame, 32'b0} |
                        {{(RD_W - FRAME_W - 8){1'b0}}, frame, 8'b0} |
                        {{(RD_W - 8){1'b0}}, RDIST_TYPER_LOW};
    // children-asleep reads back as processor-sleep
    assign waker_view = {waker_reg[DATA_W-1:3], waker_reg[1], waker_reg[1:0]};

    always_comb begin
        case (dist_off)
            DIST_CTLR_OFF:  dist_rd = {33'b0, ctlr_reg[DATA_W-2:0]};
            DIST_TYPER_OFF: dist_rd = {32'b0, DIST_TYPER_VALUE};
            DIST_IIDR_OFF:  dist_rd = {32'b0, IIDR_VALUE};
            DIST_PIDR2_OFF: dist_rd = {32'b0, PIDR2_VALUE};
            default:        dist_rd = '0;
        endcase
    end

    always_comb begin
        case (frame_off)
            RDIST_IIDR_OFF:     redist_rd = {32'b0, IIDR_VALUE};
            RDIST_TYPER_LO_OFF: redist_rd = (a_size_reg == ACCESS_WORD) ?
                                            {32'b0, typer[31:0]} : typer;
            RDIST_TYPER_HI_OFF: redist_rd = {32'b0, typer[63:32]};
            RDIST_WAKER_OFF:    redist_rd = {32'b0, waker_view};
            RDIST_PIDR2_OFF:    redist_rd = {32'b0, PIDR2_VALUE};
            default:            redist_rd = '0;
        endcase
    end

    always_comb begin
        read_data = '0;
        if (!is_write) begin
            if (dist_hit) begin
                read_data = dist_rd;
            end else if (redist_hit) begin
                read_data = redist_rd;
            end
        end
    end

    // set-enable and clear-enable ranges: offsets 0x100 to 0x1ff
    assign en_range    = (dist_off[ADDR_W-1:9] == '0) && dist_off[8];
    assign en_req.valid = a_fire && dist_hit && is_write && en_range;
    assign en_req.set   = !dist_off[7];
    assign en_req.idx   = dist_off[6:2];
    assign en_req.data  = a_data_reg;

    gicrfe_enable_bank #(
        .ENABLE_WORDS(ENABLE_WORDS)
    ) u_enable_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (en_req),
        .rsp     (en_rsp)
    );

    // ctlr and waker updates happen as the request moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctlr_reg  <= '0;
            waker_reg <= '0;
        end else if (a_fire && is_write) begin
            if (dist_hit && (dist_off == DIST_CTLR_OFF)) begin
                ctlr_reg <= a_data_reg;
            end
            if (redist_hit && (frame_off == RDIST_WAKER_OFF)) begin
                waker_reg <= a_data_reg;
            end
        end
    end

    // result stage
    assign m_data_next = {{(M_TDATA_W - RD_W - 1 - WIDX_W - DATA_W){1'b0}},
                          en_rsp.word, en_rsp.idx, en_rsp.changed, read_data};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (a_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ design/gicrfe_checker.sv @@
// port-level assertions for the gic register front end, with bind
`default_nettype none

module gicrfe_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [gicrfe_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                             cfg_valid
);
    import gicrfe_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // read data and enable report never appear together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:0] != 64'd0) |->
            (m_tdata[101:64] == 38'd0))
        else $error("read data alongside enable report");

    // an accepted request reaches the output through the input and result stages when not stalled
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after request");

    // requests wait behind a configuration write
    a_cfg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_tready)
        else $error("request taken during configuration write");

endmodule

bind gicv3_register_front_end gicrfe_checker u_gicrfe_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid)
);

`default_nettype wire

@@ sim/gicv3_register_front_end_checker.sv @@
// checker for the gic register front end: predicts each access result and compares the result stream
`timescale 1ns / 1ps

module gicv3_register_front_end_checker #(
    parameter int ENABLE_WORDS = gicrfe_pkg::ENABLE_WORDS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gicrfe_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gicrfe_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [gicrfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gicrfe_pkg::ADDR_W-1:0]    cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               compared
);
    import gicrfe_pkg::*;

    localparam logic [63:0] SET_ENABLE_OFF   = 64'h100;
    localparam logic [63:0] CLEAR_ENABLE_OFF = 64'h180;
    localparam logic [63:0] ENABLE_END_OFF   = 64'h200;
    localparam logic [63:0] SGI_HALF         = 64'h10000;
    localparam int          REPORT_LIMIT     = 10;

    // field order gives read_data in the low bits, as on m_tdata
    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic [WIDX_W-1:0] widx;
        logic              changed;
        logic [RD_W-1:0]   rd;
    } access_result_t;

    localparam int RESULT_W = $bits(access_result_t);

    logic [ADDR_W-1:0] base_dev;
    logic [ADDR_W-1:0] dist_base;
    logic [ADDR_W-1:0] dist_size;
    logic [ADDR_W-1:0] rdist_base;
    logic [ADDR_W-1:0] rdist_size;
    logic [DATA_W-1:0] ctlr_q;
    logic [DATA_W-1:0] waker_q;
    logic [DATA_W-1:0] en_words [32];

    access_result_t expected_results [$];
    int fails;
    int checked;

    function automatic logic in_window(input logic [63:0] a, input logic [ADDR_W-1:0] base,
                                       input logic [ADDR_W-1:0] size);
        return a >= {16'd0, base} && a < {16'd0, base} + {16'd0, size};
    endfunction

    // updates the register state as the block would and returns the result
    function automatic access_result_t predict_access(input logic op,
                                                      input logic [ADDR_W-1:0] offset,
                                                      input logic [DATA_W-1:0] wdata,
                                                      input logic [SIZE_W-1:0] size);
        logic [63:0]       addr;
        logic [63:0]       off;
        logic [63:0]       frame;
        logic [63:0]       typer;
        logic [63:0]       word_sel;
        logic [16:0]       reg_off;
        logic              set_op;
        logic [DATA_W-1:0] old_w;
        logic [DATA_W-1:0] new_w;
        access_result_t    r;
        r    = '0;
        addr = {16'd0, base_dev} + {16'd0, offset};
        if (in_window(addr, dist_base, dist_size)) begin
            off = addr - {16'd0, dist_base};
            if (op == OP_READ) begin
                if (off == DIST_CTLR_OFF) r.rd = {33'd0, ctlr_q[30:0]};
                else if (off == DIST_TYPER_OFF) r.rd = {32'd0, DIST_TYPER_VALUE};
                else if (off == DIST_IIDR_OFF) r.rd = {32'd0, IIDR_VALUE};
                else if (off == DIST_PIDR2_OFF) r.rd = {32'd0, PIDR2_VALUE};
            end else begin
                if (off >= SET_ENABLE_OFF && off < ENABLE_END_OFF) begin
                    set_op   = off < CLEAR_ENABLE_OFF;
                    word_sel = ((off - (set_op ? SET_ENABLE_OFF : CLEAR_ENABLE_OFF)) >> 2)
                               & 64'h1F;
                    if (word_sel < ENABLE_WORDS) begin
                        old_w = en_words[word_sel[4:0]];
                        new_w = set_op ? (old_w | wdata) : (old_w & ~wdata);
                        en_words[word_sel[4:0]] = new_w;
                        r.changed = new_w != old_w;
                        r.widx    = word_sel[4:0];
                        r.word    = new_w;
                    end
                end
                if (off == DIST_CTLR_OFF) ctlr_q = wdata;
            end
        end else if (in_window(addr, rdist_base, rdist_size)) begin
            off     = addr - {16'd0, rdist_base};
            reg_off = off[FRAME_LSB-1:0];
            if (op == OP_READ) begin
                frame = off >> FRAME_LSB;
                typer = (frame << 32) | (frame << 8) | {56'd0, RDIST_TYPER_LOW};
                if (reg_off >= SGI_HALF) r.rd = '0;
                else if (reg_off == RDIST_IIDR_OFF) r.rd = {32'd0, IIDR_VALUE};
                else if (reg_off == RDIST_TYPER_LO_OFF)
                    r.rd = (size == ACCESS_WORD) ? {32'd0, typer[31:0]} : typer;
                else if (reg_off == RDIST_TYPER_HI_OFF) r.rd = {32'd0, typer[63:32]};
                // children-asleep follows processor-sleep
                else if (reg_off == RDIST_WAKER_OFF)
                    r.rd = {32'd0, waker_q[31:3], waker_q[1], waker_q[1:0]};
                else if (reg_off == RDIST_PIDR2_OFF) r.rd = {32'd0, PIDR2_VALUE};
            end else if (reg_off == RDIST_WAKER_OFF) begin
                waker_q = wdata;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        access_result_t want;
        access_result_t got;
        if (!aresetn) begin
            base_dev   = '0;
            dist_base  = DIST_BASE_RESET;
            dist_size  = DIST_SIZE_RESET;
            rdist_base = REDIST_BASE_RESET;
            rdist_size = REDIST_SIZE_RESET;
            ctlr_q     = '0;
            waker_q    = '0;
            for (int i = 0; i < 32; i++) en_words[i] = '0;
            expected_results.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEVICE_BASE: base_dev   = cfg_data;
                    CFG_DIST_BASE:   dist_base  = cfg_data;
                    CFG_DIST_SIZE:   dist_size  = cfg_data;
                    CFG_REDIST_BASE: rdist_base = cfg_data;
                    CFG_REDIST_SIZE: rdist_size = cfg_data;
                    default: ;
                endcase
            end
            // compare before pushing: a result never belongs to a request of the same edge
            if (m_tvalid && m_tready) begin
                got = access_result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("unexpected result read_data %h changed %0d index %0d word %h",
                                 got.rd, got.changed, got.widx, got.word);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.rd !== want.rd || got.changed !== want.changed ||
                        got.widx !== want.widx || got.word !== want.word) begin
                        if (fails < REPORT_LIMIT)
                            $display({"mismatch (expected/actual): read_data %h/%h ",
                                      "changed %0d/%0d index %0d/%0d word %h/%h"},
                                     want.rd, got.rd, want.changed, got.changed,
                                     want.widx, got.widx, want.word, got.word);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_access(s_tuser, s_tdata[47:0],
                                                          s_tdata[79:48], s_tdata[83:80]));
        end
        fail_count <= fails;
        pending    <= expected_results.size();
        compared   <= checked;
    end

endmodule

@@ sim/gicv3_register_front_end_tb.sv @@
// testbench top for the gic register front end: drives requests and configuration
`timescale 1ns / 1ps

module gicv3_register_front_end_tb;
    import gicrfe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int N_MAPS        = 7;
    localparam int ITEMS_PER_MAP = 180;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [SIZE_W-1:0]    ACCESS_DWORD     = 4'd8;
    localparam logic [ADDR_W-1:0]    SET_ENABLE_OFF   = 48'h100;
    localparam logic [ADDR_W-1:0]    CLEAR_ENABLE_OFF = 48'h180;
    localparam logic [FRAME_LSB-1:0] RDIST_CTLR_OFF   = 17'h0;
    localparam logic [FRAME_LSB-1:0] RDIST_SGI_OFF    = 17'h10000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO    = CFG_REDIST_SIZE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI    = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data  = '0;

    int chk_fails;
    int chk_pending;
    int chk_compared;

    // current window map, mirrored here only to aim the stimulus
    logic [ADDR_W-1:0] cur_dev;
    logic [ADDR_W-1:0] cur_dbase;
    logic [ADDR_W-1:0] cur_dsize;
    logic [ADDR_W-1:0] cur_rbase;
    logic [ADDR_W-1:0] cur_rsize;

    logic steady    = 1'b0;   // no idling on either side while set
    logic hold_go   = 1'b0;   // asks the receiver for its long hold-off
    logic hold_done = 1'b0;
    int   sent      = 0;
    int   cycles    = 0;

    always #2 aclk = ~aclk;

    gicv3_register_front_end dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gicv3_register_front_end_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (chk_fails),
        .pending    (chk_pending),
        .compared   (chk_compared)
    );

    // roughly one idle cycle in four, none while steady
    function automatic logic take_break();
        return !steady && ($urandom_range(99) < 25);
    endfunction

    // receiver: random stalls, plus one long hold-off counted here in cycles
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 25);
            end
        end
    end

    // entered at a falling edge, returns at the falling edge after the request was taken;
    // valid stays high on return so back-to-back requests need no second assignment
    task automatic send_request(input logic op, input logic [ADDR_W-1:0] offset,
                                input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] size);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, size, data, offset};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // same timing as send_request, on the configuration channel
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        while (take_break()) begin
            cfg_valid <= 1'b0;
            @(negedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop offering, wait for every result, then let the pipeline run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_map(input int p);
        case (p)
            0: begin   // reset map written back explicitly
                cur_dev   = '0;
                cur_dbase = DIST_BASE_RESET;
                cur_dsize = DIST_SIZE_RESET;
                cur_rbase = REDIST_BASE_RESET;
                cur_rsize = REDIST_SIZE_RESET;
            end
            1: begin   // nonzero device base, eight redistributor frames
                cur_dev   = 48'h0000_0000_1000;
                cur_dbase = 48'h0000_0001_0000;
                cur_dsize = 48'h0000_0001_0000;
                cur_rbase = 48'h0000_0004_0000;
                cur_rsize = 48'h0000_0010_0000;
            end
            2: begin   // empty distributor, largest redistributor window
                cur_dev   = '0;
                cur_dbase = '0;
                cur_dsize = '0;
                cur_rbase = '0;
                cur_rsize = '1;
            end
            3: begin   // distributor sits just above the redistributor window, with no overlap
                cur_dev   = 48'h1234_5678_0000;
                cur_dbase = 48'h1234_5679_0000;
                cur_dsize = 48'h0000_0001_0000;
                cur_rbase = 48'h1234_5670_0000;
                cur_rsize = 48'h0000_0040_0000;
            end
            4: begin   // everything at the top, addresses above 48 bits
                cur_dev   = '1;
                cur_dbase = '1;
                cur_dsize = 48'h0000_0001_0000;
                cur_rbase = '1;
                cur_rsize = '1;
            end
            5: begin   // nothing mapped
                cur_dev   = '0;
                cur_dbase = '0;
                cur_dsize = '0;
                cur_rbase = '0;
                cur_rsize = '0;
            end
            default: begin
                cur_dev   = 48'($urandom_range(0, 16'hFFFF)) << 12;
                cur_dbase = ADDR_W'({$urandom, $urandom});
                cur_dsize = 48'h0000_0001_0000;
                cur_rbase = cur_dbase + 48'h0000_0001_0000;
                cur_rsize = 48'h0000_0002_0000 * ADDR_W'($urandom_range(1, 16));
            end
        endcase
        write_config(CFG_DEVICE_BASE, cur_dev);
        write_config(CFG_DIST_BASE, cur_dbase);
        write_config(CFG_DIST_SIZE, cur_dsize);
        write_config(CFG_REDIST_BASE, cur_rbase);
        write_config(CFG_REDIST_SIZE, cur_rsize);
        // writes to unused indexes must leave the map alone
        if (p == N_MAPS - 1) begin
            write_config(CFG_UNUSED_LO, ADDR_W'({$urandom, $urandom}));
            write_config(CFG_UNUSED_HI, ADDR_W'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly aimed at mapped registers, the rest is raw noise over the whole offset
    task automatic send_random();
        logic [63:0]       target;
        logic [63:0]       frames;
        logic [63:0]       frame;
        logic [ADDR_W-1:0] offset;
        logic [DATA_W-1:0] data;
        logic [SIZE_W-1:0] size;
        int                kind;
        int                pick;
        kind = $urandom_range(99);
        pick = $urandom_range(7);
        if (kind < 40) begin
            case (pick)
                0: target = 64'(DIST_CTLR_OFF);
                1: target = 64'(DIST_TYPER_OFF);
                2: target = 64'(DIST_IIDR_OFF);
                3: target = 64'(DIST_PIDR2_OFF);
                4: target = 64'(SET_ENABLE_OFF) + 64'($urandom_range(0, 8'h7F));
                5: target = 64'(CLEAR_ENABLE_OFF) + 64'($urandom_range(0, 8'h7F));
                6: target = 64'(SET_ENABLE_OFF) + 64'(4 * $urandom_range(0, 63));
                default: target = 64'($urandom_range(0, 16'hFFFF));
            endcase
            target = target + {16'd0, cur_dbase};
        end else begin
            frames = {16'd0, cur_rsize} >> FRAME_LSB;
            frame  = (frames == 0) ? 64'd0 : {32'd0, $urandom} % frames;
            case (pick)
                0: target = 64'(RDIST_CTLR_OFF);
                1: target = 64'(RDIST_IIDR_OFF);
                2: target = 64'(RDIST_TYPER_LO_OFF);
                3: target = 64'(RDIST_TYPER_HI_OFF);
                4: target = 64'(RDIST_WAKER_OFF);
                5: target = 64'(RDIST_PIDR2_OFF);
                6: target = 64'(RDIST_SGI_OFF) + 64'($urandom_range(0, 16'hFFFF));
                default: target = 64'($urandom_range(0, 17'h1FFFF));
            endcase
            target = target + {16'd0, cur_rbase} + (frame << FRAME_LSB);
        end
        if (kind < 75) offset = ADDR_W'(target - {16'd0, cur_dev});
        else offset = ADDR_W'({$urandom, $urandom});
        case ($urandom_range(3))
            0: data = $urandom;
            1: data = $urandom & $urandom & $urandom;
            2: data = 32'd1 << $urandom_range(31);
            default: data = $urandom_range(1) ? '0 : '1;
        endcase
        if ($urandom_range(3) == 0) size = SIZE_W'($urandom_range(15));
        else size = $urandom_range(1) ? ACCESS_WORD : ACCESS_DWORD;
        send_request($urandom_range(1) ? OP_WRITE : OP_READ, offset, data, size);
    endtask

    // run-away guard
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part on the reset map: distributor at 0x8000000, one frame at 0x80a0000
        send_request(OP_READ,  48'h0800_0000, 32'h0, ACCESS_WORD);          // ctlr after reset
        send_request(OP_WRITE, 48'h0800_0000, 32'hFFFF_FFFF, ACCESS_WORD);
        send_request(OP_READ,  48'h0800_0000, 32'h0, ACCESS_WORD);          // bit 31 hidden
        send_request(OP_READ,  48'h0800_0004, 32'h0, ACCESS_WORD);
        send_request(OP_READ,  48'h0800_0008, 32'h0, ACCESS_DWORD);
        send_request(OP_READ,  48'h0800_FFE8, 32'h0, ACCESS_WORD);
        send_request(OP_READ,  48'h0800_000C, 32'h0, ACCESS_WORD);          // unlisted register
        send_request(OP_WRITE, 48'h0800_0004, 32'h1234_5678, ACCESS_WORD);  // read-only, ignored
        send_request(OP_WRITE, 48'h0800_0100, 32'hFFFF_FFFF, ACCESS_WORD);  // set word 0
        send_request(OP_WRITE, 48'h0800_0100, 32'hFFFF_FFFF, ACCESS_WORD);  // no change
        send_request(OP_WRITE, 48'h0800_017C, 32'h8000_0001, ACCESS_WORD);  // set word 31
        send_request(OP_WRITE, 48'h0800_01FF, 32'h0000_0001, ACCESS_WORD);  // unaligned clear
        send_request(OP_WRITE, 48'h0800_0180, 32'h0, ACCESS_WORD);          // clear nothing
        send_request(OP_WRITE, 48'h0800_0105, 32'hA5A5_A5A5, ACCESS_WORD);  // unaligned set
        send_request(OP_READ,  48'h080A_0008, 32'h0, ACCESS_WORD);          // typer low word
        send_request(OP_READ,  48'h080A_0008, 32'h0, ACCESS_DWORD);         // typer full
        send_request(OP_READ,  48'h080A_000C, 32'h0, 4'd0);
        send_request(OP_READ,  48'h080A_0004, 32'h0, 4'd15);
        send_request(OP_WRITE, 48'h080A_0014, 32'h0000_0002, ACCESS_WORD);  // processor sleep
        send_request(OP_READ,  48'h080A_0014, 32'h0, ACCESS_WORD);
        send_request(OP_WRITE, 48'h080A_0014, 32'hFFFF_FFFD, ACCESS_WORD);  // asleep bit alone
        send_request(OP_READ,  48'h080A_0014, 32'h0, ACCESS_WORD);
        send_request(OP_READ,  48'h080A_FFE8, 32'h0, 4'd15);
        send_request(OP_READ,  48'h080B_0008, 32'h0, ACCESS_DWORD);         // sgi half
        send_request(OP_READ,  48'h0, 32'h0, 4'd0);                         // unmapped
        send_request(OP_WRITE, '1, 32'hFFFF_FFFF, 4'd15);                   // unmapped write

        for (int p = 0; p < N_MAPS; p++) begin
            settle();
            apply_map(p);
            for (int i = 0; i < ITEMS_PER_MAP; i++) begin
                // long receiver hold-off while requests keep coming
                if (p == 2 && i == 30) hold_go <= 1'b1;
                steady <= (p == 3 && i >= 40 && i < 160);
                send_random();
            end
        end
        settle();

        $display("covered %0d requests over %0d window maps plus the reset map",
                 sent, N_MAPS);
        $display("%0d results compared, %0d failures", chk_compared, chk_fails + chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
